[design/sdspi_pkg.sv]
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types and constants of the SD card SPI host engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 512;
  localparam int unsigned IDLE_BYTES_DEF  = 10;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_BYTE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_XCHG = 2'd0,
    KIND_RDAT = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOIDL = 2'd1,
    ST_RDERR = 2'd2,
    ST_WRERR = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    CFG_R1_POLL = 2'd0,
    CFG_V2_RETR = 2'd1,
    CFG_V1_RETR = 2'd2,
    CFG_BUSY    = 2'd3
  } cfg_idx_t;

  // classified front item
  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [9:0]  count;
    logic [7:0]  cb;
    logic [7:0]  wb;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       chip_select_high;
    logic       slow_clock;
    logic [7:0] read_byte;
    logic [1:0] status;
    logic [2:0] card_type;
    logic       last;
  } res_t;

endpackage

[design/sdspi_chan_if.sv]
// ----------------------------------------------------------------------------
// sdspi_chan_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface sdspi_chan_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/sd_card_spi_host_engine_top.sv]
// ----------------------------------------------------------------------------
// sd_card_spi_host_engine_top
// SD card SPI-mode host engine: init, block read and block write sequencing.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | operation, block_address, byte_count, card_byte, write_byte
// out_    | out | kind, tx_byte, chip_select_high, slow_clock, read_byte,
//         |     | status, card_type, last
// cfg_    | in  | we, index, data (16 bits)
//
// one item per cycle while neither side stalls; each transfer gives its result
// through the two-entry input queue and the output register.
// the sequencer loop state->next result sets the rate.
// synchronous active-low reset; limits return to defaults.
// either side may stall freely; a card byte arriving idle is dropped.
// ----------------------------------------------------------------------------
module sd_card_spi_host_engine_top #(
  parameter int unsigned BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned IDLE_BYTES  = sdspi_pkg::IDLE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sdspi_chan_if.sink  in_ch,
  sdspi_chan_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sdspi_pkg::*;

  logic        q_valid, q_ready, busy;
  cmd_t        q_cmd, in_cmd;
  logic [7:0]  r1_r;
  logic [15:0] v2_r, v1_r, bz_r;

  assign in_cmd = in_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_r <= 8'd10; v2_r <= 16'd12000; v1_r <= 16'd25000; bz_r <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_R1_POLL: r1_r <= cfg_data[7:0];
        CFG_V2_RETR: v2_r <= cfg_data;
        CFG_V1_RETR: v1_r <= cfg_data;
        default:     bz_r <= cfg_data;
      endcase
    end
  end

  sdspi_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd,
    .busy, .q_valid, .q_ready, .q_cmd
  );

  sdspi_back #(.BLOCK_BYTES(BLOCK_BYTES), .IDLE_BYTES(IDLE_BYTES)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .busy,
    .r1_lim(r1_r), .v2_lim(v2_r), .v1_lim(v1_r), .busy_lim(bz_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(out_ch.data)
  );
endmodule

[design/sdspi_front.sv]
// ----------------------------------------------------------------------------
// sdspi_front
// Input stage: clamps byte count, drops card bytes seen while idle, queues.
// ----------------------------------------------------------------------------
module sdspi_front #(
  parameter int unsigned BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sdspi_pkg::cmd_t  in_cmd,
  input  logic             busy,      // back end has an operation running
  output logic             q_valid,
  input  logic             q_ready,
  output sdspi_pkg::cmd_t  q_cmd
);
  import sdspi_pkg::*;

  // two-entry queue
  cmd_t       mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push, pop, idle_drop;
  cmd_t       cl;
  logic       run_r, run_nxt; // operation in flight counting queued starts

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];
  assign pop      = q_valid && q_ready;

  // a card byte while no operation is running or queued gives no result
  assign idle_drop = (in_cmd.op == OP_BYTE) && !run_r;

  assign push = in_valid && in_ready && !idle_drop;

  always_comb begin
    cl = in_cmd;
    if (in_cmd.count == '0) cl.count = 10'd1;
    else if ({22'd0, in_cmd.count} > BLOCK_BYTES) cl.count = 10'(BLOCK_BYTES);
  end

  // run_r mirrors whether the back end will be busy once queue drains:
  // a start makes it busy; busy falling with empty queue clears it
  always_comb begin
    run_nxt = run_r;
    if (in_valid && in_ready && in_cmd.op != OP_BYTE) run_nxt = 1'b1;
    else if (!busy && cnt_r == 2'd0 && !(in_valid && in_ready)) run_nxt = 1'b0;
  end

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0; run_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      run_r <= run_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cl;
  end
endmodule

[design/sdspi_back.sv]
// ----------------------------------------------------------------------------
// sdspi_back
// Protocol sequencer: at most one result per queued item into an output register.
// ----------------------------------------------------------------------------
module sdspi_back #(
  parameter int unsigned BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned IDLE_BYTES  = sdspi_pkg::IDLE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  sdspi_pkg::cmd_t  q_cmd,
  output logic             busy,
  input  logic [7:0]       r1_lim,
  input  logic [15:0]      v2_lim,
  input  logic [15:0]      v1_lim,
  input  logic [15:0]      busy_lim,
  output logic             out_valid,
  input  logic             out_ready,
  output sdspi_pkg::res_t  out_res
);
  import sdspi_pkg::*;

  typedef enum logic [20:0] {
    PH_IDLE   = 21'd1 << 0,  PH_WAKE   = 21'd1 << 1,  PH_CDESEL = 21'd1 << 2,
    PH_CSEL   = 21'd1 << 3,  PH_CFRAME = 21'd1 << 4,  PH_CPOLL  = 21'd1 << 5,
    PH_GAP0   = 21'd1 << 6,  PH_OCR8   = 21'd1 << 7,  PH_OCR58  = 21'd1 << 8,
    PH_RGAP   = 21'd1 << 9,  PH_RTOKEN = 21'd1 << 10, PH_RDATA  = 21'd1 << 11,
    PH_RTAIL1 = 21'd1 << 12, PH_RTAIL2 = 21'd1 << 13, PH_WGAP   = 21'd1 << 14,
    PH_WTOKEN = 21'd1 << 15, PH_WDATA  = 21'd1 << 16, PH_WTAIL1 = 21'd1 << 17,
    PH_WTAIL2 = 21'd1 << 18, PH_WRESP  = 21'd1 << 19, PH_WBUSY  = 21'd1 << 20
  } phase_t;

  typedef enum logic [3:0] {
    NX_CMD0, NX_CMD8, NX_V2, NX_CMD58, NX_PROBE, NX_V1, NX_CMD16, NX_CMD17, NX_CMD24
  } nx_t;

  phase_t      ph_r, ph_nxt;
  logic [47:0] frm_r, frm_nxt;
  logic [15:0] bc_r, bc_nxt, rc_r, rc_nxt;
  logic [31:0] ocr_r, ocr_nxt, ad_r, ad_nxt, aarg_r, aarg_nxt;
  logic [2:0]  ty_r, ty_nxt;
  logic [9:0]  sc_r, sc_nxt;
  nx_t         nx_r, nx_nxt;
  logic        app_r, app_nxt;
  logic [5:0]  aidx_r, aidx_nxt;
  logic        ov_r;
  res_t        res_r, res_nxt;
  logic        has_res;
  logic [15:0] bc1;
  logic [31:0] ocrs;
  logic [7:0]  cb;

  assign busy      = (ph_r != PH_IDLE);
  assign q_ready   = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign cb        = q_cmd.cb;
  assign bc1       = bc_r + 16'd1;
  assign ocrs      = {ocr_r[23:0], cb};

  always_comb begin : seq
    logic [5:0]  iidx;
    logic [31:0] iarg;
    logic        iapp, do_issue, do_fin, do_res;
    logic [1:0]  fst;
    nx_t         inx;
    logic [7:0]  rr;
    logic [7:0]  crc;
    logic [5:0]  fi;
    logic [31:0] fa;
    ph_nxt = ph_r; frm_nxt = frm_r; bc_nxt = bc_r; rc_nxt = rc_r;
    ocr_nxt = ocr_r; ty_nxt = ty_r; ad_nxt = ad_r; sc_nxt = sc_r;
    nx_nxt = nx_r; app_nxt = app_r; aidx_nxt = aidx_r; aarg_nxt = aarg_r;
    has_res = 1'b1;
    res_nxt = '0;
    res_nxt.tx_byte = 8'hFF;
    iidx = '0; iarg = '0; iapp = 1'b0; inx = NX_CMD0;
    do_issue = 1'b0; do_fin = 1'b0; do_res = 1'b0; fst = ST_OK; rr = cb;
    crc = 8'h01; fi = '0; fa = '0;

    if (q_cmd.op == OP_INIT) begin
      ty_nxt = '0; bc_nxt = '0; app_nxt = 1'b0; ph_nxt = PH_WAKE;
      res_nxt.chip_select_high = 1'b1; res_nxt.slow_clock = 1'b1;
    end else if (q_cmd.op == OP_READ || q_cmd.op == OP_WRITE) begin
      ad_nxt = q_cmd.addr; sc_nxt = q_cmd.count;
      do_issue = 1'b1; iarg = q_cmd.addr;
      iidx = (q_cmd.op == OP_READ) ? 6'd17 : 6'd24;
      inx  = (q_cmd.op == OP_READ) ? NX_CMD17 : NX_CMD24;
    end else begin
      unique case (ph_r)
        PH_IDLE: has_res = 1'b0;
        PH_WAKE: begin
          bc_nxt = bc1;
          if (bc1 < 16'(IDLE_BYTES)) begin
            res_nxt.chip_select_high = 1'b1; res_nxt.slow_clock = 1'b1;
          end else begin
            do_issue = 1'b1; inx = NX_CMD0;
          end
        end
        PH_CDESEL: ph_nxt = PH_CSEL;
        PH_CSEL: begin
          ph_nxt = PH_CFRAME; bc_nxt = 16'd1; res_nxt.tx_byte = frm_r[47:40];
        end
        PH_CFRAME: begin
          if (bc_r < 16'd6) begin
            case (bc_r[2:0])
              3'd1:    res_nxt.tx_byte = frm_r[39:32];
              3'd2:    res_nxt.tx_byte = frm_r[31:24];
              3'd3:    res_nxt.tx_byte = frm_r[23:16];
              3'd4:    res_nxt.tx_byte = frm_r[15:8];
              default: res_nxt.tx_byte = frm_r[7:0];
            endcase
            bc_nxt = bc1;
          end else begin
            bc_nxt = '0; ph_nxt = PH_CPOLL;
          end
        end
        PH_CPOLL: begin
          bc_nxt = bc1;
          if (cb[7] && bc1 < {8'd0, r1_lim}) begin
            // keep polling
          end else if (app_r) begin
            if (cb > 8'd1) begin
              app_nxt = 1'b0; do_res = 1'b1;
            end else begin
              do_issue = 1'b1; iidx = aidx_r; iarg = aarg_r; inx = nx_r;
            end
          end else do_res = 1'b1;
        end
        PH_GAP0: begin
          do_issue = 1'b1; iidx = 6'd8; iarg = 32'h1AA; inx = NX_CMD8;
        end
        PH_OCR8, PH_OCR58: begin
          ocr_nxt = ocrs; bc_nxt = bc1;
          if (bc1 < 16'd4) begin
          end else if (ph_r == PH_OCR8) begin
            if (ocrs[15:8] == 8'h01 && ocrs[7:0] == 8'hAA) begin
              rc_nxt = v2_lim;
              if (v2_lim == '0) begin
                ty_nxt = '0; do_fin = 1'b1;
              end else begin
                do_issue = 1'b1; iidx = 6'd41; iarg = 32'h4000_0000;
                iapp = 1'b1; inx = NX_V2;
              end
            end else do_fin = 1'b1;
          end else begin
            ty_nxt = ocrs[30] ? 3'd4 : 3'd3; do_fin = 1'b1;
          end
        end
        PH_RGAP: begin bc_nxt = '0; ph_nxt = PH_RTOKEN; end
        PH_RTOKEN: begin
          bc_nxt = bc1;
          if (cb == 8'hFE) begin
            bc_nxt = '0; ph_nxt = PH_RDATA;
          end else if (bc1 >= busy_lim) begin
            do_fin = 1'b1; fst = ST_RDERR;
          end
        end
        PH_RDATA: begin
          bc_nxt = bc1;
          if (bc1 >= {6'd0, sc_r}) ph_nxt = PH_RTAIL1;
          res_nxt.kind = KIND_RDAT; res_nxt.read_byte = cb;
        end
        PH_RTAIL1: ph_nxt = PH_RTAIL2;
        PH_RTAIL2: do_fin = 1'b1;
        PH_WGAP: begin ph_nxt = PH_WTOKEN; res_nxt.tx_byte = 8'hFE; end
        PH_WTOKEN: begin
          bc_nxt = '0; ph_nxt = PH_WDATA; res_nxt.tx_byte = q_cmd.wb;
        end
        PH_WDATA: begin
          bc_nxt = bc1;
          if (bc1 < {6'd0, sc_r}) res_nxt.tx_byte = q_cmd.wb;
          else ph_nxt = PH_WTAIL1;
        end
        PH_WTAIL1: ph_nxt = PH_WTAIL2;
        PH_WTAIL2: ph_nxt = PH_WRESP;
        PH_WRESP: begin
          if (cb[4:0] != 5'h05) begin
            do_fin = 1'b1; fst = ST_WRERR;
          end else begin
            bc_nxt = '0; ph_nxt = PH_WBUSY;
          end
        end
        PH_WBUSY: begin
          bc_nxt = bc1;
          if (cb == 8'hFF) do_fin = 1'b1;
          else if (bc1 >= busy_lim) begin
            do_fin = 1'b1; fst = ST_WRERR;
          end
        end
        default: has_res = 1'b0;
      endcase
    end

    // command response resolution
    if (do_res) begin
      unique case (nx_r)
        NX_CMD0: begin
          if (rr == 8'd1) ph_nxt = PH_GAP0;
          else begin do_fin = 1'b1; fst = ST_NOIDL; end
        end
        NX_CMD8: begin
          if (rr == 8'd1) begin
            bc_nxt = '0; ocr_nxt = '0; ph_nxt = PH_OCR8;
          end else begin
            do_issue = 1'b1; iidx = 6'd41; iapp = 1'b1; inx = NX_PROBE;
          end
        end
        NX_V2: begin
          if (rr != 8'd0) begin
            rc_nxt = rc_r - 16'd1;
            if (rc_nxt == '0) begin ty_nxt = '0; do_fin = 1'b1; end
            else begin
              do_issue = 1'b1; iidx = 6'd41; iarg = 32'h4000_0000;
              iapp = 1'b1; inx = NX_V2;
            end
          end else begin
            do_issue = 1'b1; iidx = 6'd58; inx = NX_CMD58;
          end
        end
        NX_CMD58: begin
          if (rr == 8'd0) begin
            bc_nxt = '0; ocr_nxt = '0; ph_nxt = PH_OCR58;
          end else do_fin = 1'b1;
        end
        NX_PROBE, NX_V1: begin
          if (nx_r == NX_PROBE) begin
            ty_nxt = (rr <= 8'd1) ? 3'd2 : 3'd1; rc_nxt = v1_lim;
          end else if (rr != 8'd0) rc_nxt = rc_r - 16'd1;
          if (nx_r == NX_V1 && rr == 8'd0) begin
            do_issue = 1'b1; iidx = 6'd16; iarg = 32'(BLOCK_BYTES);
            inx = NX_CMD16;
          end else if (rc_nxt == '0) begin
            ty_nxt = '0; do_fin = 1'b1;
          end else begin
            do_issue = 1'b1; inx = NX_V1;
            if (ty_nxt == 3'd2) begin iidx = 6'd41; iapp = 1'b1; end
            else iidx = 6'd1;
          end
        end
        NX_CMD16: begin
          if (rr != 8'd0) ty_nxt = '0;
          do_fin = 1'b1;
        end
        NX_CMD17: begin
          if (rr != 8'd0) begin do_fin = 1'b1; fst = ST_RDERR; end
          else ph_nxt = PH_RGAP;
        end
        default: begin
          if (rr != 8'd0) begin do_fin = 1'b1; fst = ST_WRERR; end
          else ph_nxt = PH_WGAP;
        end
      endcase
    end

    if (do_issue) begin
      app_nxt = iapp; aidx_nxt = iidx; aarg_nxt = iarg; nx_nxt = inx;
      fi = iapp ? 6'd55 : iidx;
      fa = iapp ? 32'd0 : iarg;
      if (fi == 6'd0) crc = 8'h95;
      else if (fi == 6'd8) crc = 8'h87;
      frm_nxt = {2'b01, fi, fa, crc};
      ph_nxt = PH_CDESEL;
      res_nxt = '0; res_nxt.tx_byte = 8'hFF; res_nxt.chip_select_high = 1'b1;
    end

    if (do_fin) begin
      ph_nxt = PH_IDLE;
      res_nxt = '0;
      res_nxt.kind = KIND_DONE; res_nxt.status = fst;
      res_nxt.card_type = ty_nxt; res_nxt.last = 1'b1;
    end
  end

  logic take;
  assign take = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; ov_r <= 1'b0; bc_r <= '0; rc_r <= '0; ocr_r <= '0;
      ty_r <= '0; ad_r <= '0; sc_r <= '0; frm_r <= '0; nx_r <= NX_CMD0;
      app_r <= 1'b0; aidx_r <= '0; aarg_r <= '0;
    end else begin
      if (out_ready) ov_r <= 1'b0;
      if (take) begin
        ph_r <= ph_nxt; frm_r <= frm_nxt; bc_r <= bc_nxt; rc_r <= rc_nxt;
        ocr_r <= ocr_nxt; ty_r <= ty_nxt; ad_r <= ad_nxt; sc_r <= sc_nxt;
        nx_r <= nx_nxt; app_r <= app_nxt; aidx_r <= aidx_nxt; aarg_r <= aarg_nxt;
        if (has_res) ov_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_res) res_r <= res_nxt;
  end
endmodule
